// ===== sv/ifbf_pkg.sv =====
// Shared constants and types for the IPv4 flow block filter.
// Depends on nothing; imported by ifbf_ram users and the top level.
package ifbf_pkg;

  localparam int TABLE_ENTRIES    = 64;
  localparam int IDX_W            = $clog2(TABLE_ENTRIES);
  localparam int MAX_PACKET_BYTES = 65535;
  localparam int POS_W            = 16;
  localparam int KEY_W            = 104;

  localparam logic [3:0] IP_VERSION    = 4'd4;
  localparam logic [3:0] IHL_MASK      = 4'hF;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [POS_W-1:0] MIN_HDR = 16'd20;
  localparam logic [POS_W-1:0] TCP_NEED = 16'd4;
  localparam logic [POS_W-1:0] UDP_NEED = 16'd8;

  // Input kinds carried on tuser.
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_VERDICT = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [KEY_W-1:0] key_t;

endpackage

// ===== sv/ifbf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ifbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ipv4_flow_block_filter.sv =====
// IPv4 flow block filter: parses headers from a byte stream and checks the
// five-tuple against a blocked-flow table held in one RAM.
// A non-final byte only updates the parse state. A final byte with a good
// header scans the table one entry a cycle, then gives the result beat; a
// bad header gives its beat without a scan. A drop verdict runs two passes
// of scan and write, one per flow direction. A held result beat stalls the input.
// Synchronous reset clears parse state, valid bits and the replace pointer.
module ipv4_flow_block_filter (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // data_byte[7:0], verdict_is_drop[8], flow_src_addr[40:9], flow_dst_addr[72:41],
  // flow_sport[88:73], flow_dport[104:89], flow_protocol[112:105]
  input  logic [119:0] s_tdata,
  // command
  input  logic         s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_src_addr[31:0], out_dst_addr[63:32], out_sport[79:64],
  // out_dport[95:80], out_protocol[103:96]
  output logic [103:0] m_tdata,
  // drop[0], header_valid[1]
  output logic [1:0]   m_tuser
);
  import ifbf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIN, S_OUT} state_t;

  state_t            state;
  logic [POS_W-1:0]  pos;
  logic [7:0]        vl;
  logic [7:0]        proto;
  logic [63:0]       addrs;
  logic [31:0]       ports;
  logic [TABLE_ENTRIES-1:0] valid;
  idx_t              rp;
  key_t              key, key2;
  logic              inserting, phase;
  logic [IDX_W:0]    cnt;
  logic              cmp_v, cmp_ok, hit, free_found;
  idx_t              free_idx;
  logic              res_hv;
  logic              ram_we;
  idx_t              ram_waddr;
  key_t              ram_rdata;

  // Next parse state for the incoming byte.
  logic [7:0]        b;
  logic [7:0]        vl_next, proto_next;
  logic [63:0]       addrs_next;
  logic [31:0]       ports_next;
  logic [POS_W-1:0]  pos_next, hl, rel, avail;
  logic [2:0]        aidx;
  logic              ok, l4;
  logic [15:0]       sp, dp;

  always_comb begin
    b          = s_tdata[7:0];
    vl_next    = vl;
    proto_next = proto;
    addrs_next = addrs;
    ports_next = ports;
    pos_next   = pos;
    // Byte lane of the address word: offset 12 lands in the top byte.
    aidx       = 3'd3 - pos[2:0];
    if (pos != POS_W'(MAX_PACKET_BYTES)) begin
      if (pos == '0) vl_next = b;
      if (pos == 16'd9) proto_next = b;
      if (pos >= 16'd12 && pos < 16'd20) begin
        addrs_next[{aidx, 3'b000} +: 8] = b;
      end
      pos_next = pos + 1'b1;
    end
    hl  = {10'd0, vl_next[3:0] & IHL_MASK, 2'b00};
    rel = pos - hl;
    if (pos != POS_W'(MAX_PACKET_BYTES) && pos >= hl && rel < 16'd4) begin
      ports_next[(2'd3 - rel[1:0]) * 8 +: 8] = b;
    end
    avail = pos_next - hl;
    ok = pos_next >= MIN_HDR && vl_next[7:4] == IP_VERSION && hl >= MIN_HDR
         && hl <= pos_next;
    l4 = proto_next == PROTO_TCP || proto_next == PROTO_UDP;
    if (ok && proto_next == PROTO_TCP && avail < TCP_NEED) ok = 1'b0;
    if (ok && proto_next == PROTO_UDP && avail < UDP_NEED) ok = 1'b0;
    sp = l4 ? ports_next[31:16] : 16'd0;
    dp = l4 ? ports_next[15:0] : 16'd0;
  end

  assign s_tready  = state == S_IDLE;
  assign ram_we    = state == S_FIN && inserting && !hit;
  assign ram_waddr = free_found ? free_idx : rp;

  ifbf_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Control, parse state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos      <= '0;
      vl       <= '0;
      proto    <= '0;
      addrs    <= '0;
      ports    <= '0;
      valid    <= '0;
      rp       <= '0;
      m_tvalid <= 1'b0;
      cnt      <= '0;
      cmp_v    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt        <= '0;
          cmp_v      <= 1'b0;
          hit        <= 1'b0;
          free_found <= 1'b0;
          phase      <= 1'b0;
          if (s_tvalid && s_tuser == CMD_VERDICT) begin
            if (s_tdata[8]) begin
              key   <= {s_tdata[40:9], s_tdata[72:41], s_tdata[88:73],
                        s_tdata[104:89], s_tdata[112:105]};
              key2  <= {s_tdata[72:41], s_tdata[40:9], s_tdata[104:89],
                        s_tdata[88:73], s_tdata[112:105]};
              inserting <= 1'b1;
              state <= S_SCAN;
            end
          end else if (s_tvalid) begin
            if (s_tlast) begin
              pos   <= '0;
              vl    <= '0;
              proto <= '0;
              addrs <= '0;
              ports <= '0;
              inserting <= 1'b0;
              res_hv <= ok;
              key   <= ok ? {addrs_next, sp, dp, proto_next} : '0;
              state <= ok ? S_SCAN : S_OUT;
            end else begin
              pos   <= pos_next;
              vl    <= vl_next;
              proto <= proto_next;
              addrs <= addrs_next;
              ports <= ports_next;
            end
          end
        end
        S_SCAN: begin
          // Issue one read a cycle; compare the entry read the cycle before.
          cmp_v <= !cnt[IDX_W];
          if (!cnt[IDX_W]) begin
            cnt    <= cnt + 1'b1;
            cmp_ok <= valid[cnt[IDX_W-1:0]];
            if (!valid[cnt[IDX_W-1:0]] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cnt[IDX_W-1:0];
            end
          end
          if (cmp_v && cmp_ok && ram_rdata == key) hit <= 1'b1;
          if (cnt[IDX_W] && !cmp_v) state <= S_FIN;
        end
        S_FIN: begin
          if (!inserting) begin
            state <= S_OUT;
          end else begin
            if (!hit) begin
              valid[ram_waddr] <= 1'b1;
              if (!free_found) begin
                rp <= (rp == idx_t'(TABLE_ENTRIES - 1)) ? '0 : rp + 1'b1;
              end
            end
            cnt        <= '0;
            cmp_v      <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            key        <= key2;
            phase      <= 1'b1;
            state      <= phase ? S_IDLE : S_SCAN;
          end
        end
        S_OUT: begin
          // Present the result beat once the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {res_hv, res_hv & hit};
            m_tdata  <= {key[7:0], key[23:8], key[39:24], key[71:40], key[103:72]};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
